// File: rtl/bks_pkg.sv
// Shared types, opcodes and key-compare function for the bounded key set.
// No dependencies.
package bks_pkg;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_INSERT_NEW = 2'd2;
    localparam logic [1:0] OP_REMOVE     = 2'd3;

    localparam logic [63:0] EXP_MASK = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] MAN_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
    } t_in;

    typedef struct packed {
        logic       found;
        logic       stored;
        logic       removed;
        logic       overflow;
        logic [4:0] entry_count;
    } t_out;

    // token walking down the cell chain
    typedef struct packed {
        logic valid;
        logic found;
        logic free;
    } t_tok;

    // broadcast update applied by the chosen cell
    typedef struct packed {
        logic write;
        logic clear;
    } t_commit;

    function automatic logic is_nan(input logic [63:0] k);
        return ((k & EXP_MASK) == EXP_MASK) && ((k & MAN_MASK) != 64'd0);
    endfunction

    function automatic logic keys_match(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (a == b) begin
            res = 1'b1;
        end else begin
            res = ((a & MAG_MASK) == 64'd0) && ((b & MAG_MASK) == 64'd0);
        end
        return res;
    endfunction

endpackage

// File: rtl/bks_cell.sv
// One key slot of the chain: key, valid bit and the pass-through token stage.
// Depends on bks_pkg.
module bks_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_key,
    input  bks_pkg::t_tok    i_tok,
    input  bks_pkg::t_commit i_commit,
    output bks_pkg::t_tok    o_tok
);
    import bks_pkg::*;

    logic [63:0] r_key;
    logic        r_valid;
    logic        r_cand_free;
    logic        r_cand_match;
    t_tok        r_tok;
    t_tok        n_tok;
    logic        hit;

    always_comb begin
        hit         = r_valid && keys_match(r_key, i_key);
        n_tok.valid = i_tok.valid;
        n_tok.found = i_tok.found | hit;
        n_tok.free  = i_tok.free | ~r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_cand_free  <= 1'b0;
            r_cand_match <= 1'b0;
            r_tok        <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_cand_free  <= ~r_valid & ~i_tok.free;
                r_cand_match <= hit & ~i_tok.found;
            end
            if (i_commit.write && r_cand_free) begin
                r_valid <= 1'b1;
            end
            if (i_commit.clear && r_cand_match) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.write && r_cand_free) begin
            r_key <= i_key;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/bounded_key_set.sv
// Bounded key set: CAPACITY slots in a chain of cells, one token hop per cycle.
// The item is registered, its token walks the cell chain and the walk result is registered;
// the commit lands once the output can take it, and no new item is taken before the commit.
// Synchronous active-low reset empties every slot and clears the count.
// Depends on bks_pkg and bks_cell.
module bounded_key_set #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bks_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bks_pkg::t_out o_out_data
);
    import bks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_in           r_item;
    logic          r_start;
    logic          r_found;
    logic          r_free;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    t_out          n_out;
    t_commit       commit;
    logic          can_load;
    logic          ins;
    logic [CW+4:0] cnt_ext;

    t_tok tok [CAPACITY+1];

    assign tok[0] = '{valid: r_start, found: 1'b0, free: 1'b0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bks_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_key    (r_item.key),
            .i_tok    (tok[g]),
            .i_commit (commit),
            .o_tok    (tok[g+1])
        );
    end

    always_comb begin
        can_load = !r_out_valid || !i_out_stall;
        ins      = (r_item.opcode == OP_INSERT) ||
                   ((r_item.opcode == OP_INSERT_NEW) && !r_found);
        commit.write = 1'b0;
        commit.clear = 1'b0;
        n_state  = r_state;
        n_count  = r_count;
        n_out    = r_out;
        cnt_ext  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (tok[CAPACITY].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (can_load) begin
                    commit.write = ins && r_free;
                    commit.clear = (r_item.opcode == OP_REMOVE) && r_found;
                    if (commit.write) begin
                        n_count = r_count + CW'(1);
                    end else if (commit.clear) begin
                        n_count = r_count - CW'(1);
                    end
                    cnt_ext           = {5'd0, n_count};
                    n_out.found       = r_found;
                    n_out.stored      = commit.write;
                    n_out.removed     = commit.clear;
                    n_out.overflow    = ins && !r_free;
                    n_out.entry_count = cnt_ext[4:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_IDLE) && i_in_valid;
            r_count <= n_count;
            if ((r_state == S_DONE) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_item <= i_in_data;
        end
        if ((r_state == S_WALK) && tok[CAPACITY].valid) begin
            r_found <= tok[CAPACITY].found;
            r_free  <= tok[CAPACITY].free;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/sv/tb_bounded_key_set.sv
// Self-checking testbench for bounded_key_set: lookup, insert, insert-if-absent and remove
// against a shadow copy of the key slots, with random bursts and output back-pressure.
// Depends on bks_pkg and the bounded_key_set RTL.
module tb_bounded_key_set;
    import bks_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_SIZE    = 8;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
    typedef enum logic {TREND_FILL, TREND_DRAIN} trend_e;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    logic [63:0] shadow_key [CAPACITY];
    logic        shadow_used [CAPACITY];
    int unsigned shadow_count = 0;
    t_out        status_due [$];
    logic [63:0] key_pool [POOL_SIZE];

    int          bad_status  = 0;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    bit          offering    = 1'b0;
    logic        hold_req    = 1'b0;
    int          hold_left   = 0;
    int          stall_phase = 0;
    stall_mode_e stall_mode  = STALL_NONE;

    bounded_key_set #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit key_is_nan(input logic [63:0] k);
        return (k[62:52] == 11'h7FF) && (k[51:0] != 52'd0);
    endfunction

    function automatic bit key_eq(input logic [63:0] a, input logic [63:0] b);
        if (key_is_nan(a) || key_is_nan(b)) begin
            return 1'b0;
        end
        return (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
    endfunction

    function automatic t_out set_update(input logic [1:0] op, input logic [63:0] key);
        t_out res;
        int   hit;
        int   free_slot;
        hit       = -1;
        free_slot = -1;
        for (int s = CAPACITY - 1; s >= 0; s--) begin
            if (shadow_used[s] && key_eq(shadow_key[s], key)) begin
                hit = s;
            end
            if (!shadow_used[s]) begin
                free_slot = s;
            end
        end
        res       = '0;
        res.found = (hit >= 0);
        if (op == OP_INSERT || (op == OP_INSERT_NEW && hit < 0)) begin
            if (free_slot >= 0) begin
                shadow_key[free_slot]  = key;
                shadow_used[free_slot] = 1'b1;
                shadow_count++;
                res.stored = 1'b1;
            end else begin
                res.overflow = 1'b1;
            end
        end else if (op == OP_REMOVE && hit >= 0) begin
            shadow_used[hit] = 1'b0;
            shadow_count--;
            res.removed = 1'b1;
        end
        res.entry_count = shadow_count[4:0];
        return res;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_plain_key();
        logic [63:0] k;
        k = rand_key();
        if (key_is_nan(k)) begin
            k[62] = 1'b0;
        end
        return k;
    endfunction

    // pick a stored, matchable key; give zeros a random sign
    function automatic logic [63:0] live_key(input logic [63:0] fallback);
        int          idx [$];
        logic [63:0] k;
        for (int s = 0; s < CAPACITY; s++) begin
            if (shadow_used[s] && !key_is_nan(shadow_key[s])) begin
                idx.push_back(s);
            end
        end
        if (idx.size() == 0) begin
            return fallback;
        end
        k = shadow_key[idx[$urandom_range(idx.size() - 1)]];
        if (k[62:0] == 63'd0) begin
            k[63] = 1'($urandom_range(1));
        end
        return k;
    endfunction

    function automatic void refresh_pool();
        for (int p = 0; p < POOL_SIZE; p++) begin
            key_pool[p] = rand_plain_key();
        end
        key_pool[0] = {$urandom_range(1) ? 1'b1 : 1'b0, 63'd0};
        key_pool[1] = {$urandom_range(1) ? 1'b1 : 1'b0, 11'h7FF, 52'd0};
    endfunction

    function automatic logic [63:0] pool_key();
        if ($urandom_range(4) == 0) begin
            return rand_plain_key();
        end
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic send_op(input logic [1:0] op, input logic [63:0] key);
        t_in item;
        int  gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        item.opcode = op;
        item.key    = key;
        i_in_data  <= item;
        i_in_valid <= 1'b1;
        offering    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        status_due.push_back(set_update(op, key));
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
        end
        burst_left = 0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_ops();
        send_op(OP_LOOKUP, 64'd0);
        send_op(OP_REMOVE, 64'd0);
        wait_drained();
    endtask

    task automatic test_signed_zero();
        send_op(OP_INSERT,     64'h0000_0000_0000_0000);
        send_op(OP_LOOKUP,     64'h8000_0000_0000_0000);
        send_op(OP_INSERT_NEW, 64'h8000_0000_0000_0000);
        send_op(OP_INSERT,     64'h0000_0000_0000_0000);
        send_op(OP_REMOVE,     64'h8000_0000_0000_0000);
        wait_drained();
    endtask

    task automatic test_nan_keys();
        send_op(OP_INSERT,     64'h7FF8_0000_0000_0000);
        send_op(OP_LOOKUP,     64'h7FF8_0000_0000_0000);
        send_op(OP_INSERT_NEW, 64'h7FF0_0000_0000_0001);
        send_op(OP_REMOVE,     64'h7FF0_0000_0000_0001);
        send_op(OP_INSERT,     64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_fill_overflow();
        send_op(OP_INSERT, 64'h7FF0_0000_0000_0000);
        send_op(OP_INSERT, 64'hFFF0_0000_0000_0000);
        send_op(OP_INSERT, 64'h7FEF_FFFF_FFFF_FFFF);
        while (shadow_count < CAPACITY) begin
            send_op(OP_INSERT_NEW, rand_plain_key());
        end
        send_op(OP_INSERT,     64'h3FF0_0000_0000_0000);
        send_op(OP_INSERT_NEW, 64'h4000_0000_0000_0001);
        send_op(OP_INSERT_NEW, 64'h7FF0_0000_0000_0000);
        send_op(OP_REMOVE,     64'h7FF0_0000_0000_0000);
        wait_drained();
    endtask

    task automatic send_random_op(input trend_e trend);
        int          r;
        logic [63:0] k;
        r = $urandom_range(99);
        if (r >= 90) begin
            k = rand_key();
            if ($urandom_range(3) == 0) begin
                k[62:52] = 11'h7FF;
                k[0]     = 1'b1;
            end
            send_op($urandom_range(1) ? OP_LOOKUP : OP_REMOVE, k);
        end else if (trend == TREND_FILL) begin
            if (r < 35) begin
                send_op(OP_INSERT, pool_key());
            end else if (r < 60) begin
                send_op(OP_INSERT_NEW, pool_key());
            end else if (r < 75) begin
                send_op(OP_REMOVE, live_key(pool_key()));
            end else begin
                send_op(OP_LOOKUP, $urandom_range(1) ? live_key(pool_key()) : pool_key());
            end
        end else begin
            if (r < 10) begin
                send_op(OP_INSERT, pool_key());
            end else if (r < 20) begin
                send_op(OP_INSERT_NEW, pool_key());
            end else if (r < 70) begin
                send_op(OP_REMOVE, live_key(pool_key()));
            end else begin
                send_op(OP_LOOKUP, $urandom_range(1) ? live_key(pool_key()) : pool_key());
            end
        end
    endtask

    task automatic test_output_holdoff();
        hold_req <= 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_random_op(TREND_FILL);
        end
        wait_drained();
    endtask

    task automatic test_random_mix(input int count);
        trend_e trend;
        trend = TREND_FILL;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                trend = $urandom_range(1) ? TREND_FILL : TREND_DRAIN;
                if ($urandom_range(1)) begin
                    refresh_pool();
                end
            end
            if (n % 100 == 99) begin
                wait_drained();
            end
            send_random_op(trend);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  <= stall_mode_e'($urandom_range(3));
                stall_phase <= $urandom_range(16, 80);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(3) != 0);
                default:     i_out_stall <= ((cycle_count % 7) < 3);
            endcase
        end
    end

    task automatic compare_field(input string name, input logic [4:0] want,
                                 input logic [4:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_status++;
        end
    endtask

    always @(posedge i_clk) begin : check_status
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", o_out_data);
                bad_status++;
            end else begin
                want = status_due.pop_front();
                compare_field("found",       5'(want.found),    5'(o_out_data.found));
                compare_field("stored",      5'(want.stored),   5'(o_out_data.stored));
                compare_field("removed",     5'(want.removed),  5'(o_out_data.removed));
                compare_field("overflow",    5'(want.overflow), 5'(o_out_data.overflow));
                compare_field("entry_count", want.entry_count,  o_out_data.entry_count);
            end
        end
    end

    initial begin
        for (int s = 0; s < CAPACITY; s++) begin
            shadow_key[s]  = 64'd0;
            shadow_used[s] = 1'b0;
        end
        refresh_pool();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ops();
        test_signed_zero();
        test_nan_keys();
        test_fill_overflow();
        test_output_holdoff();
        test_random_mix(400);
        repeat (2 * CAPACITY + 8) @(posedge i_clk);
        if (bad_status == 0 && status_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
